/* rtl/core/lts_pkg.sv */
// shared constants, types and helper functions for the lux to sky brightness block
`timescale 1ns / 1ps
`default_nettype none
package lts_pkg;

  localparam int QB        = 24;
  localparam int LOG_STEPS = QB;
  localparam int EXP_STEPS = 30;
  localparam int LO_W      = 31;

  localparam logic signed [63:0] QMASK = 64'sd16777215;

  localparam logic signed [31:0] C_OFFSET_SKY = 32'sd211392922;
  localparam logic signed [31:0] C_K_SKY      = 32'sd12626113;
  localparam logic signed [31:0] C_K_NELM     = 32'sd25252226;
  localparam logic signed [31:0] C_X0         = 32'sd72410464;
  localparam logic signed [31:0] C_LOG2_10    = 32'sd55732705;
  localparam logic signed [31:0] C_NELM0      = 32'sd133043323;
  localparam logic signed [31:0] NELM_MIN_SKY = 32'sd251658240;
  localparam logic signed [31:0] Z_OFS        = 32'sd402653184;
  localparam logic signed [31:0] Z_MAX        = 32'sd520093696;
  localparam logic [29:0]        DIV5_MUL     = 30'd858993460;

  localparam logic REG_MIN_LUX = 1'b0;

  // smallest value whose hundredfold reaches th * 2^24
  function automatic logic signed [31:0] hund_th(input longint th);
    return 32'((th * 64'sd16777216 + 64'sd99) / 100);
  endfunction

  localparam logic signed [31:0] BORTLE_TH [8] = '{
    hund_th(2199), hund_th(2189), hund_th(2169), hund_th(2049),
    hund_th(1950), hund_th(1894), hund_th(1838), hund_th(1700)
  };

  typedef struct packed {
    logic [31:0] clamped;
    logic [12:0] sky;
    logic [3:0]  cls;
    logic        cond;
  } fin_t;

  // division by 2^24 with truncation toward zero
  function automatic logic signed [63:0] tdiv_q(input logic signed [63:0] p);
    logic signed [63:0] a;
    a = p[63] ? p + QMASK : p;
    return a >>> QB;
  endfunction

  function automatic logic [5:0] msb_idx(input logic [32:0] v);
    logic [5:0] idx;
    idx = '0;
    for (int i = 0; i < 33; i++) begin
      if (v[i]) idx = 6'(i);
    end
    return idx;
  endfunction

  // mantissa with the leading one at bit 31
  function automatic logic [31:0] norm_m(input logic [32:0] v, input logic [5:0] e);
    logic [32:0] s;
    if (e >= 6'd31) s = v >> (e - 6'd31);
    else s = v << (6'd31 - e);
    return s[31:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/lts_if.sv */
// input and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface lts_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] lux_reading;
  modport source (output valid, output lux_reading, input ready);
  modport sink (input valid, input lux_reading, output ready);
endinterface

interface lts_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] clamped_lux;
  logic [12:0] sky_brightness;
  logic [10:0] limiting_magnitude;
  logic [3:0]  bortle_class;
  modport source (output valid, output clamped_lux, output sky_brightness,
                  output limiting_magnitude, output bortle_class, input ready);
  modport sink (input valid, input clamped_lux, input sky_brightness,
                input limiting_magnitude, input bortle_class, output ready);
endinterface
`default_nettype wire

/* rtl/core/lts_sq_log.sv */
// pipelined fraction of log2 by repeated squaring, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none
module lts_sq_log #(
  parameter int SIDE_W = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [31:0]            m_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   valid_o,
  output logic [lts_pkg::QB-1:0] r_o,
  output logic [SIDE_W-1:0]      side_o
);
  import lts_pkg::*;

  logic              v_q [LOG_STEPS];
  logic [31:0]       m_q [LOG_STEPS];
  logic [QB-1:0]     r_q [LOG_STEPS];
  logic [SIDE_W-1:0] s_q [LOG_STEPS];

  for (genvar s = 0; s < LOG_STEPS; s++) begin : g_stage
    logic              v_in;
    logic [31:0]       m_in;
    logic [QB-1:0]     r_in;
    logic [SIDE_W-1:0] s_in;
    logic [63:0]       sq;
    logic [32:0]       nxt;

    if (s == 0) begin : g_first
      assign v_in = valid_i;
      assign m_in = m_i;
      assign r_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[s-1];
      assign m_in = m_q[s-1];
      assign r_in = r_q[s-1];
      assign s_in = s_q[s-1];
    end

    assign sq  = 64'(m_in) * 64'(m_in);
    assign nxt = sq[63:31];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[s] <= 1'b0;
      else if (en_i) v_q[s] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (nxt[32]) begin
          m_q[s] <= nxt[32:1];
          r_q[s] <= r_in | (QB'(1) << (QB - 1 - s));
        end else begin
          m_q[s] <= nxt[31:0];
          r_q[s] <= r_in;
        end
        s_q[s] <= s_in;
      end
    end
  end

  assign valid_o = v_q[LOG_STEPS-1];
  assign r_o     = r_q[LOG_STEPS-1];
  assign side_o  = s_q[LOG_STEPS-1];

endmodule
`default_nettype wire

/* rtl/core/lts_exp2.sv */
// pipelined 2^f mantissa search, one mantissa bit per step of squaring stages
`timescale 1ns / 1ps
`default_nettype none
module lts_exp2 #(
  parameter int SIDE_W = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [lts_pkg::QB-1:0]   f_i,
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     valid_o,
  output logic [lts_pkg::LO_W-1:0] lo_o,
  output logic [SIDE_W-1:0]        side_o
);
  import lts_pkg::*;

  localparam int CW = LO_W + QB + SIDE_W;

  logic              v_q  [EXP_STEPS];
  logic [LO_W-1:0]   lo_q [EXP_STEPS];
  logic [QB-1:0]     f_q  [EXP_STEPS];
  logic [SIDE_W-1:0] s_q  [EXP_STEPS];

  for (genvar b = 0; b < EXP_STEPS; b++) begin : g_step
    localparam logic [LO_W-1:0] BIT = LO_W'(1) << (EXP_STEPS - 1 - b);
    logic              v_in;
    logic [LO_W-1:0]   lo_in;
    logic [QB-1:0]     f_in;
    logic [SIDE_W-1:0] s_in;
    logic [LO_W-1:0]   cand;
    logic              c_v;
    logic [QB-1:0]     c_r;
    logic [CW-1:0]     c_side;
    logic [LO_W-1:0]   c_lo;
    logic [QB-1:0]     c_f;
    logic [SIDE_W-1:0] c_s;

    if (b == 0) begin : g_first
      assign v_in  = valid_i;
      assign lo_in = LO_W'(1) << (LO_W - 1);
      assign f_in  = f_i;
      assign s_in  = side_i;
    end else begin : g_next
      assign v_in  = v_q[b-1];
      assign lo_in = lo_q[b-1];
      assign f_in  = f_q[b-1];
      assign s_in  = s_q[b-1];
    end

    assign cand = lo_in | BIT;

    lts_sq_log #(.SIDE_W(CW)) u_log (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (v_in),
      .m_i     ({cand, 1'b0}),
      .side_i  ({lo_in, f_in, s_in}),
      .valid_o (c_v),
      .r_o     (c_r),
      .side_o  (c_side)
    );

    assign {c_lo, c_f, c_s} = c_side;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[b] <= 1'b0;
      else if (en_i) v_q[b] <= c_v;
    end

    // keep the candidate bit when its log2 fraction does not pass f
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lo_q[b] <= (c_r <= c_f) ? (c_lo | BIT) : c_lo;
        f_q[b]  <= c_f;
        s_q[b]  <= c_s;
      end
    end
  end

  assign valid_o = v_q[EXP_STEPS-1];
  assign lo_o    = lo_q[EXP_STEPS-1];
  assign side_o  = s_q[EXP_STEPS-1];

endmodule
`default_nettype wire

/* rtl/core/lux_to_sky_brightness_top.sv */
// lux to sky brightness, limiting magnitude and bortle class, top level
// throughput: one beat per cycle; a result left untaken holds the whole pipeline
// latency is set by the 2^x search: 30 mantissa bits, each 24 squaring stages
// reset clears all valid bits and sets min_lux to 7; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module lux_to_sky_brightness_top #(
  parameter int LUX_FRAC_BITS = 16,
  parameter int MAG_FRAC_BITS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lts_in_if.sink       in_if,
  lts_out_if.source    out_if,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import lts_pkg::*;

  localparam logic signed [31:0] LUX_OFS = 32'(LUX_FRAC_BITS * (1 << QB));
  localparam int MAG_SH = QB - MAG_FRAC_BITS;
  localparam int FW = $bits(fin_t);

  logic        en;
  logic [16:0] min_lux_q;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) min_lux_q <= 17'd7;
    else if (psel && penable && pwrite && paddr == REG_MIN_LUX) min_lux_q <= pwdata[16:0];
  end

  always_comb begin
    case (paddr)
      REG_MIN_LUX: prdata = {15'b0, min_lux_q};
      default:     prdata = '0;
    endcase
  end

  logic out_v_q;
  assign en          = !out_v_q || out_if.ready;
  assign in_if.ready = en;

  // s1 clamp, s2 leading one, s3 normalize
  logic        v1_q, v2_q, v3_q;
  logic [31:0] cl1_q, cl2_q, cl3_q;
  logic [5:0]  e2_q, e3_q;
  logic [31:0] m3_q;
  logic [16:0] floor_lux;
  logic [31:0] cl_d;

  assign floor_lux = (min_lux_q == '0) ? 17'd1 : min_lux_q;
  assign cl_d = (in_if.lux_reading < 32'(floor_lux)) ? 32'(floor_lux) : in_if.lux_reading;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cl1_q <= cl_d;
      cl2_q <= cl1_q;
      e2_q  <= msb_idx({1'b0, cl1_q});
      cl3_q <= cl2_q;
      e3_q  <= e2_q;
      m3_q  <= norm_m({1'b0, cl2_q}, e2_q);
    end
  end

  logic        l1_v;
  logic [QB-1:0] l1_r;
  logic [37:0] l1_side;
  logic [31:0] l1_cl;
  logic [5:0]  l1_e;

  lts_sq_log #(.SIDE_W(38)) u_log_lux (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .m_i     (m3_q),
    .side_i  ({cl3_q, e3_q}),
    .valid_o (l1_v),
    .r_o     (l1_r),
    .side_o  (l1_side)
  );
  assign {l1_cl, l1_e} = l1_side;

  // s4 t, s5 product, s6 sky, s7 outputs and /5 product, s8 x, s9 product, s10 z
  logic               v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q;
  logic [31:0]        cl4_q, cl5_q, cl6_q;
  logic signed [31:0] t4_q, sky6_q, x8_q;
  logic signed [63:0] p5_q, p9_q;
  logic [59:0]        d7_q;
  fin_t               fin7_q, fin8_q, fin9_q, fin10_q;
  logic [4:0]         n10_q;
  logic [QB-1:0]      f10_q;
  fin_t               fin_d;
  logic [31:0]        sky_sh;
  logic signed [31:0] y_d, z_d;

  always_comb begin
    fin_d.clamped = cl6_q;
    sky_sh = 32'(sky6_q >>> MAG_SH);
    if (sky6_q <= 0) fin_d.sky = '0;
    else if (sky_sh > 32'd8191) fin_d.sky = 13'h1fff;
    else fin_d.sky = sky_sh[12:0];
    fin_d.cond = (sky6_q >= NELM_MIN_SKY);
    fin_d.cls = 4'd9;
    for (int i = 7; i >= 0; i--) begin
      if (sky6_q >= BORTLE_TH[i]) fin_d.cls = 4'(i + 1);
    end
  end

  always_comb begin
    y_d = 32'(tdiv_q(p9_q));
    z_d = y_d + Z_OFS;
    if (z_d < 0) z_d = '0;
    else if (z_d > Z_MAX) z_d = Z_MAX;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cl4_q   <= l1_cl;
      t4_q    <= LUX_OFS - signed'({2'b0, l1_e, l1_r});
      cl5_q   <= cl4_q;
      p5_q    <= 64'(t4_q) * 64'(C_K_SKY);
      cl6_q   <= cl5_q;
      sky6_q  <= C_OFFSET_SKY + 32'(tdiv_q(p5_q));
      fin7_q  <= fin_d;
      d7_q    <= 60'(sky6_q[29:0]) * 60'(DIV5_MUL);
      fin8_q  <= fin7_q;
      x8_q    <= C_X0 - signed'({4'b0, d7_q[59:32]});
      fin9_q  <= fin8_q;
      p9_q    <= 64'(x8_q) * 64'(C_LOG2_10);
      fin10_q <= fin9_q;
      n10_q   <= z_d[28:24];
      f10_q   <= z_d[23:0];
    end
  end

  logic            x_v;
  logic [LO_W-1:0] x_lo;
  logic [FW+4:0]   x_side;
  logic [4:0]      x_n;
  fin_t            x_fin;

  lts_exp2 #(.SIDE_W(FW + 5)) u_exp2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v10_q),
    .f_i     (f10_q),
    .side_i  ({n10_q, fin10_q}),
    .valid_o (x_v),
    .lo_o    (x_lo),
    .side_o  (x_side)
  );
  assign {x_n, x_fin} = x_side;

  // s11 w = 2^y + 1, s12 leading one, s13 normalize
  logic        v11_q, v12_q, v13_q;
  fin_t        fin11_q, fin12_q, fin13_q;
  logic [32:0] w11_q, w12_q;
  logic [5:0]  e12_q, e13_q;
  logic [31:0] m13_q;
  logic [32:0] pw;

  always_comb begin
    if (x_n >= 5'd30) pw = {2'b0, x_lo} << (x_n - 5'd30);
    else pw = {2'b0, x_lo} >> (5'd30 - x_n);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin11_q <= x_fin;
      w11_q   <= pw + 33'(1 << QB);
      fin12_q <= fin11_q;
      w12_q   <= w11_q;
      e12_q   <= msb_idx(w11_q);
      fin13_q <= fin12_q;
      e13_q   <= e12_q;
      m13_q   <= norm_m(w12_q, e12_q);
    end
  end

  logic          l2_v;
  logic [QB-1:0] l2_r;
  logic [FW+5:0] l2_side;
  logic [5:0]    l2_e;
  fin_t          l2_fin;

  lts_sq_log #(.SIDE_W(FW + 6)) u_log_w (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v13_q),
    .m_i     (m13_q),
    .side_i  ({e13_q, fin13_q}),
    .valid_o (l2_v),
    .r_o     (l2_r),
    .side_o  (l2_side)
  );
  assign {l2_e, l2_fin} = l2_side;

  // s14 g, s15 product, s16 limiting magnitude into the output register
  logic               v14_q, v15_q;
  fin_t               fin14_q, fin15_q;
  logic signed [31:0] g14_q;
  logic signed [63:0] p15_q;
  logic signed [31:0] nelm;
  logic [31:0]        nelm_sh;
  logic [10:0]        nelm_out;
  logic [31:0]        o_cl_q;
  logic [12:0]        o_sky_q;
  logic [10:0]        o_nelm_q;
  logic [3:0]         o_cls_q;

  always_comb begin
    nelm = fin15_q.cond ? C_NELM0 - 32'(tdiv_q(p15_q)) : '0;
    nelm_sh = 32'(nelm >>> MAG_SH);
    if (nelm <= 0) nelm_out = '0;
    else if (nelm_sh > 32'd2047) nelm_out = 11'h7ff;
    else nelm_out = nelm_sh[10:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin14_q  <= l2_fin;
      g14_q    <= signed'({2'b0, l2_e, l2_r}) - Z_OFS;
      fin15_q  <= fin14_q;
      p15_q    <= 64'(g14_q) * 64'(C_K_NELM);
      o_cl_q   <= fin15_q.clamped;
      o_sky_q  <= fin15_q.sky;
      o_cls_q  <= fin15_q.cls;
      o_nelm_q <= nelm_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
      v9_q <= 1'b0; v10_q <= 1'b0; v11_q <= 1'b0; v12_q <= 1'b0;
      v13_q <= 1'b0; v14_q <= 1'b0; v15_q <= 1'b0; out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= in_if.valid;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= l1_v;
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      v7_q    <= v6_q;
      v8_q    <= v7_q;
      v9_q    <= v8_q;
      v10_q   <= v9_q;
      v11_q   <= x_v;
      v12_q   <= v11_q;
      v13_q   <= v12_q;
      v14_q   <= l2_v;
      v15_q   <= v14_q;
      out_v_q <= v15_q;
    end
  end

  assign out_if.valid              = out_v_q;
  assign out_if.clamped_lux        = o_cl_q;
  assign out_if.sky_brightness     = o_sky_q;
  assign out_if.limiting_magnitude = o_nelm_q;
  assign out_if.bortle_class       = o_cls_q;

endmodule
`default_nettype wire
